[src/pcpm_pkg.sv]
// ----------------------------------------------------------------------------
// pcpm_pkg
// Shared constants, types and helpers of the PN correlator peak magnitude unit.
// ----------------------------------------------------------------------------
package pcpm_pkg;

    // Bank size and derived widths
    localparam int NUM_CHIPS  = 64;
    localparam int ACC_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int PATTERN_W  = 64;
    localparam int MAG_LAT    = 4;
    localparam int CNT_W      = $clog2(NUM_CHIPS + MAG_LAT + 1);
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    // Action codes of an input item
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Register index (paddr bit 3)
    localparam logic REG_CHIP_PATTERN = 1'b0;

    // Contents of one accumulator cell
    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic                    sat;
    } t_cell_data;

    // Controls broadcast to every cell
    typedef struct packed {
        logic acc_en;
        logic rot_en;
    } t_cell_ctrl;

    // Controls of the magnitude pipeline
    typedef struct packed {
        logic clr;
        logic head_valid;
    } t_mag_ctrl;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DRAIN,
        ST_ROOT,
        ST_OUT
    } t_state;

    // Clamp a 33-bit sum to signed 32 bits
    function automatic logic [ACC_W-1:0] clamp_acc(input logic [ACC_W:0] v);
        logic [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/pcpm_cell.sv]
// ----------------------------------------------------------------------------
// pcpm_cell
// One complex accumulator of the bank: accumulates, loads, or takes its
// neighbor's contents when the bank rotates.
// ----------------------------------------------------------------------------
module pcpm_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pcpm_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                 i_wr_en,
    input  logic                                 i_neg,
    input  logic signed [pcpm_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [pcpm_pkg::SAMPLE_W-1:0] i_sample_im,
    input  logic signed [pcpm_pkg::ACC_W-1:0]    i_load_re,
    input  logic signed [pcpm_pkg::ACC_W-1:0]    i_load_im,
    input  pcpm_pkg::t_cell_data                 i_nbr,
    output pcpm_pkg::t_cell_data                 o_data
);
    import pcpm_pkg::*;

    t_cell_data              r_data;
    t_cell_data              n_data;
    logic signed [ACC_W:0]   w_add_re;
    logic signed [ACC_W:0]   w_add_im;
    logic signed [ACC_W:0]   w_sum_re;
    logic signed [ACC_W:0]   w_sum_im;

    // Add or subtract the sample as the chip says
    always_comb begin
        w_add_re = i_neg ? -(33'(i_sample_re)) : 33'(i_sample_re);
        w_add_im = i_neg ? -(33'(i_sample_im)) : 33'(i_sample_im);
        w_sum_re = {r_data.re[ACC_W-1], r_data.re} + w_add_re;
        w_sum_im = {r_data.im[ACC_W-1], r_data.im} + w_add_im;
    end

    // Pick load, accumulate, rotate or hold
    always_comb begin
        n_data = r_data;
        if (i_wr_en) begin
            n_data.re  = i_load_re;
            n_data.im  = i_load_im;
            n_data.sat = 1'b0;
        end else if (i_ctrl.acc_en) begin
            n_data.re  = clamp_acc(w_sum_re);
            n_data.im  = clamp_acc(w_sum_im);
            n_data.sat = (w_sum_re[ACC_W] != w_sum_re[ACC_W-1]) ||
                         (w_sum_im[ACC_W] != w_sum_im[ACC_W-1]);
        end else if (i_ctrl.rot_en) begin
            n_data = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[src/pcpm_mag.sv]
// ----------------------------------------------------------------------------
// pcpm_mag
// Magnitude pipeline: absolute value, squares, sum and running maximum of the
// entries that pass the head of the bank, plus the OR of their clip flags.
// ----------------------------------------------------------------------------
module pcpm_mag (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcpm_pkg::t_mag_ctrl  i_ctrl,
    input  pcpm_pkg::t_cell_data i_head,
    output logic [63:0]          o_best,
    output logic                 o_sat
);
    import pcpm_pkg::*;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [ACC_W-1:0]  r_abs_re;
    logic [ACC_W-1:0]  r_abs_im;
    logic [63:0]       r_sq_re;
    logic [63:0]       r_sq_im;
    logic [63:0]       r_sum;
    logic [63:0]       r_best;
    logic              r_sat;
    logic [ACC_W-1:0]  w_u_re;
    logic [ACC_W-1:0]  w_u_im;

    assign w_u_re = i_head.re;
    assign w_u_im = i_head.im;

    // Valid chain and flag collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_best <= '0;
            r_sat  <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.head_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_ctrl.clr) begin
                r_best <= '0;
                r_sat  <= 1'b0;
            end else begin
                if (i_ctrl.head_valid) begin
                    r_sat <= r_sat | i_head.sat;
                end
                if (r_v3 && (r_sum > r_best)) begin
                    r_best <= r_sum;
                end
            end
        end
    end

    // Datapath: abs, square, sum
    always_ff @(posedge i_clk) begin
        r_abs_re <= w_u_re[ACC_W-1] ? (~w_u_re + 32'd1) : w_u_re;
        r_abs_im <= w_u_im[ACC_W-1] ? (~w_u_im + 32'd1) : w_u_im;
        r_sq_re  <= 64'(r_abs_re) * 64'(r_abs_re);
        r_sq_im  <= 64'(r_abs_im) * 64'(r_abs_im);
        r_sum    <= r_sq_re + r_sq_im;
    end

    assign o_best = r_best;
    assign o_sat  = r_sat;

endmodule

[src/pcpm_isqrt.sv]
// ----------------------------------------------------------------------------
// pcpm_isqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pcpm_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    import pcpm_pkg::*;

    logic [63:0]           r_val;
    logic [33:0]           r_rem;
    logic [31:0]           r_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [35:0]           w_rem_sh;
    logic [35:0]           w_trial;
    logic [35:0]           w_diff;
    logic                  w_take;

    // One digit of the root recurrence
    always_comb begin
        w_rem_sh = {r_rem, r_val[63:62]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        w_take   = (w_rem_sh >= w_trial);
    end

    // Control: busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ROOT_CNT_W'(ROOT_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift radicand, update remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= w_take ? w_diff[33:0] : w_rem_sh[33:0];
            r_root <= {r_root[30:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[src/pn_correlator_peak_magnitude_unit.sv]
// ----------------------------------------------------------------------------
// pn_correlator_peak_magnitude_unit
// Bank of complex PN correlators with peak magnitude detect.
// ----------------------------------------------------------------------------
// A write item loads one accumulator and gives no result. An accumulate
// item updates all NUM_CHIPS cells at once, then the bank rotates through
// the magnitude pipeline one cell per cycle, the pipeline drains, the
// two-bit-per-cycle root unit runs and the output phase loads the result.
// The input stays stalled from the accept of an accumulate item until the
// sequencer is back in idle. The output phase waits while an earlier result
// is still stalled in the output register. A result waits in the output
// register while the next item is taken. chip_pattern sits at byte
// address 0 of the APB port and must only be written while no accumulate
// item is in flight.
// ----------------------------------------------------------------------------
module pn_correlator_peak_magnitude_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic signed [pcpm_pkg::SAMPLE_W-1:0] i_sample_re,
    input  logic signed [pcpm_pkg::SAMPLE_W-1:0] i_sample_im,
    input  logic [5:0]                           i_entry_index,
    input  logic signed [pcpm_pkg::ACC_W-1:0]    i_load_re,
    input  logic signed [pcpm_pkg::ACC_W-1:0]    i_load_im,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [31:0]                          o_peak_magnitude,
    output logic                                 o_saturated,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready
);
    import pcpm_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [PATTERN_W-1:0]   r_chip_pattern;
    logic                   r_out_valid;
    logic [31:0]            r_peak;
    logic                   r_sat;

    logic                   w_in_accept;
    logic                   w_wr_ok;
    logic                   w_out_load;
    logic                   w_root_start;
    logic                   w_root_done;
    logic [31:0]            w_root;
    logic [63:0]            w_best;
    logic                   w_mag_sat;
    t_cell_ctrl             w_cell_ctrl;
    t_mag_ctrl              w_mag_ctrl;
    t_cell_data             w_cell [NUM_CHIPS];

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_CHIP_PATTERN) ? r_chip_pattern : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_pattern <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[3] == REG_CHIP_PATTERN)) begin
            r_chip_pattern <= pwdata;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && (i_action == ACT_ACCUM)) begin
                    n_state = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (r_cnt == CNT_W'(NUM_CHIPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CNT_W'(MAG_LAT)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall             = (r_state != ST_IDLE);
        w_in_accept            = i_in_valid && (r_state == ST_IDLE);
        w_cell_ctrl.acc_en     = w_in_accept && (i_action == ACT_ACCUM);
        w_cell_ctrl.rot_en     = (r_state == ST_ROTATE);
        w_wr_ok                = w_in_accept && (i_action == ACT_WRITE) &&
                                 ({1'b0, i_entry_index} < 7'(NUM_CHIPS));
        w_mag_ctrl.clr         = w_cell_ctrl.acc_en;
        w_mag_ctrl.head_valid  = w_cell_ctrl.rot_en;
        w_root_start           = (r_state == ST_DRAIN) && (r_cnt == CNT_W'(MAG_LAT));
        w_out_load             = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Row of accumulator cells, rotating toward cell 0
    for (genvar k = 0; k < NUM_CHIPS; k++) begin : g_cell
        pcpm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_cell_ctrl),
            .i_wr_en     (w_wr_ok && (i_entry_index == 6'(k))),
            .i_neg       (r_chip_pattern[k]),
            .i_sample_re (i_sample_re),
            .i_sample_im (i_sample_im),
            .i_load_re   (i_load_re),
            .i_load_im   (i_load_im),
            .i_nbr       (w_cell[(k + 1) % NUM_CHIPS]),
            .o_data      (w_cell[k])
        );
    end

    pcpm_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mag_ctrl),
        .i_head  (w_cell[0]),
        .o_best  (w_best),
        .o_sat   (w_mag_sat)
    );

    pcpm_isqrt u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_best),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_peak <= w_root;
            r_sat  <= w_mag_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_peak_magnitude = r_peak;
    assign o_saturated      = r_sat;

`ifndef SYNTH
    a_acc_starts_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_ACCUM)) |=> (r_state == ST_ROTATE))
        else $error("accumulate item did not start the rotation");

    a_root_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == ST_ROOT))
        else $error("root unit finished outside the root phase");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result appeared without passing the output phase");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_magnitude <= 32'd3037000499))
        else $error("peak magnitude out of range");
`endif

endmodule
